>>> sv/array_list_with_binary_search_defines.svh
// Assertion helpers for the list block.
`ifndef ARRAY_LIST_WITH_BINARY_SEARCH_DEFINES_SVH
`define ARRAY_LIST_WITH_BINARY_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ALBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ALBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/albs_pkg.sv
package albs_pkg;

	// Field widths
	localparam int MODE_W = 3;
	localparam int VAL_W  = 64;
	localparam int POS_W  = 10;
	localparam int IDX_W  = 11;
	localparam int LEN_W  = 11;
	localparam int STAT_W = 2;

	// Search bounds run from -1 up to 2047, signed, with headroom
	localparam int SRCH_W = IDX_W + 2;

	localparam int CAPACITY_DEF = 1024;

	// Request codes
	localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
	localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_EXEC,
		SQ_SHIFT,
		SQ_SRCH,
		SQ_CMP,
		SQ_RDWAIT,
		SQ_DONE
	} seq_state_t;

endpackage

>>> sv/array_list_with_binary_search.sv
// Fixed-capacity list of signed 64-bit entries behind a valid/ready request channel and a
// valid/ready result channel, one result transaction per request transaction. A request is
// taken only while the sequencer is idle; the result sits in an output register, so a new
// request may be taken while the previous result still waits. Append, pop, unknown modes and
// any flagged error go from execute straight to done; read first waits for one registered
// read of the entry RAM. Remove-at shifts the tail down one entry per cycle through the
// single-port-read, single-port-write RAM, overlapping the read of one entry with the write
// of the one before. Search reuses one 64-bit signed comparator: each probe is a RAM read
// then a compare, and a search that runs out of range ends on a closing bound check.
// list_size always reports the length after the request. The RAM has no reset and needs no
// clearing pass: only entries below the current length are ever read.
`include "array_list_with_binary_search_defines.svh"

module array_list_with_binary_search #(
	parameter int CAPACITY = albs_pkg::CAPACITY_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic        [albs_pkg::MODE_W-1:0]   mode,
	input  logic signed [albs_pkg::VAL_W-1:0]    item_value,
	input  logic        [albs_pkg::POS_W-1:0]    position,
	input  logic        [albs_pkg::IDX_W-1:0]    range_start,
	input  logic signed [albs_pkg::IDX_W-1:0]    range_end,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [albs_pkg::VAL_W-1:0]    read_value,
	output logic        [albs_pkg::IDX_W-1:0]    found_index,
	output logic        [albs_pkg::LEN_W-1:0]    list_size,
	output logic        [albs_pkg::STAT_W-1:0]   status
);
	import albs_pkg::*;

	// count needs to hold CAPACITY itself; RAM address only CAPACITY-1
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	// common width for index-against-length compares
	localparam int XW = (CW > IDX_W) ? CW : IDX_W;

	seq_state_t state_q, state_d;

	logic [CW-1:0] count_q;

	// latched request
	logic        [MODE_W-1:0] mode_q;
	logic signed [VAL_W-1:0]  val_q;
	logic        [POS_W-1:0]  pos_q;
	logic        [IDX_W-1:0]  rs_q;
	logic signed [IDX_W-1:0]  re_q;

	// result being built
	logic signed [VAL_W-1:0]  res_rv_q;
	logic        [IDX_W-1:0]  res_fi_q;
	logic        [STAT_W-1:0] res_st_q;

	// output register
	logic                     out_valid_q;
	logic signed [VAL_W-1:0]  read_value_q;
	logic        [IDX_W-1:0]  found_index_q;
	logic        [LEN_W-1:0]  list_size_q;
	logic        [STAT_W-1:0] status_q;

	// remove-at shift: read index runs two entries ahead of the pending write address
	logic [CW-1:0] rd_idx_q;
	logic          pend_q;
	logic [AW-1:0] pend_addr_q;

	// binary search bounds and probe
	logic signed [SRCH_W-1:0] lo_q, hi_q, mid_q;
	logic signed [SRCH_W:0]   sum_c;
	logic signed [SRCH_W-1:0] mid_c;

	// entry RAM
	logic        [VAL_W-1:0]  entry_mem [CAPACITY];
	logic signed [VAL_W-1:0]  rdata_q;
	logic                     mem_we, mem_re;
	logic        [AW-1:0]     mem_waddr, mem_raddr;
	logic        [VAL_W-1:0]  mem_wdata;

	// decode terms
	logic cnt_full, cnt_empty, pos_oob, re_err, more_rd, srch_open, hit, out_load;

	assign cnt_full  = (count_q == CW'(CAPACITY));
	assign cnt_empty = (count_q == '0);
	assign pos_oob   = (XW'(pos_q) >= XW'(count_q));
	// range_end below -1, or at/after the current length
	assign re_err    = (re_q[IDX_W-1] && (re_q != '1)) ||
	                   (!re_q[IDX_W-1] && (XW'($unsigned(re_q)) >= XW'(count_q)));
	assign more_rd   = (rd_idx_q < count_q);
	assign srch_open = (lo_q <= hi_q);
	assign hit       = (rdata_q == val_q);
	assign out_load  = (state_q == SQ_DONE) && (!out_valid_q || out_ready);

	// midpoint; both bounds are non-negative while a probe is due
	assign sum_c = (SRCH_W + 1)'(lo_q) + (SRCH_W + 1)'(hi_q);
	assign mid_c = sum_c[SRCH_W:1];

	assign in_ready = (state_q == SQ_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: begin
				if (in_valid) state_d = SQ_EXEC;
			end
			SQ_EXEC: begin
				priority if (mode_q == MODE_REMOVE && !cnt_empty && !pos_oob) begin
					state_d = SQ_SHIFT;
				end else if (mode_q == MODE_SEARCH && !re_err) begin
					state_d = SQ_SRCH;
				end else if (mode_q == MODE_READ && !pos_oob) begin
					state_d = SQ_RDWAIT;
				end else begin
					state_d = SQ_DONE;
				end
			end
			SQ_SHIFT: begin
				if (!more_rd) state_d = SQ_DONE;
			end
			SQ_SRCH: begin
				state_d = srch_open ? SQ_CMP : SQ_DONE;
			end
			SQ_CMP: begin
				state_d = hit ? SQ_DONE : SQ_SRCH;
			end
			SQ_RDWAIT: begin
				state_d = SQ_DONE;
			end
			SQ_DONE: begin
				if (!out_valid_q || out_ready) state_d = SQ_IDLE;
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	// RAM controls
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			SQ_EXEC: begin
				if (mode_q == MODE_APPEND && !cnt_full) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(count_q);
					mem_wdata = val_q;
				end
				if (mode_q == MODE_READ && !pos_oob) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(pos_q);
				end
			end
			SQ_SHIFT: begin
				if (more_rd) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(rd_idx_q);
				end
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = pend_addr_q;
					mem_wdata = rdata_q;
				end
			end
			SQ_SRCH: begin
				if (srch_open) begin
					mem_re    = 1'b1;
					mem_raddr = AW'($unsigned(mid_c));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= entry_mem[mem_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == SQ_EXEC) begin
				pend_q <= 1'b0;
				if (mode_q == MODE_APPEND && !cnt_full) count_q <= count_q + CW'(1);
				if (mode_q == MODE_POP && !cnt_empty)   count_q <= count_q - CW'(1);
			end
			if (state_q == SQ_SHIFT) begin
				pend_q <= more_rd;
				if (!more_rd) count_q <= count_q - CW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			SQ_IDLE: begin
				if (in_valid) begin
					mode_q <= mode;
					val_q  <= item_value;
					pos_q  <= position;
					rs_q   <= range_start;
					re_q   <= range_end;
				end
			end
			SQ_EXEC: begin
				res_rv_q <= '0;
				res_fi_q <= '0;
				res_st_q <= ST_OK;
				lo_q     <= $signed(SRCH_W'(rs_q));
				hi_q     <= SRCH_W'(re_q);
				rd_idx_q <= CW'(pos_q) + CW'(1);
				unique case (mode_q)
					MODE_APPEND: if (cnt_full)  res_st_q <= ST_FULL;
					MODE_POP:    if (cnt_empty) res_st_q <= ST_EMPTY;
					MODE_REMOVE: begin
						if (cnt_empty)    res_st_q <= ST_EMPTY;
						else if (pos_oob) res_st_q <= ST_RANGE;
					end
					MODE_SEARCH: if (re_err)  res_st_q <= ST_RANGE;
					MODE_READ:   if (pos_oob) res_st_q <= ST_RANGE;
					default: begin
					end
				endcase
			end
			SQ_SHIFT: begin
				if (more_rd) begin
					rd_idx_q    <= rd_idx_q + CW'(1);
					pend_addr_q <= AW'(rd_idx_q - CW'(1));
				end
			end
			SQ_SRCH: begin
				if (srch_open) mid_q <= mid_c;
				else           res_fi_q <= IDX_W'(hi_q + SRCH_W'(1));
			end
			SQ_CMP: begin
				if (hit)                  res_fi_q <= IDX_W'(mid_q);
				else if (rdata_q > val_q) hi_q <= mid_q - SRCH_W'(1);
				else                      lo_q <= mid_q + SRCH_W'(1);
			end
			SQ_RDWAIT: begin
				res_rv_q <= rdata_q;
			end
			SQ_DONE: begin
				if (out_load) begin
					read_value_q  <= res_rv_q;
					found_index_q <= res_fi_q;
					list_size_q   <= LEN_W'(count_q);
					status_q      <= res_st_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign found_index = found_index_q;
	assign list_size   = list_size_q;
	assign status      = status_q;

	// a full flag only when the length really sits at capacity
	`ALBS_ASSERT_NOW(a_full_len, out_valid && status == ST_FULL, list_size == LEN_W'(CAPACITY), "full status with short list")
	// an empty flag only on an empty list
	`ALBS_ASSERT_NOW(a_empty_len, out_valid && status == ST_EMPTY, list_size == '0, "empty status with entries")
	// the length moves only while a request is being worked
	`ALBS_ASSERT_NEXT(a_idle_count, state_q == SQ_IDLE, $stable(count_q), "length changed while idle")
	// the length never passes capacity
	`ALBS_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CW'(CAPACITY), "length above capacity")

endmodule
